[rtl/core/pawp_pkg.sv]
// Shared types and constants for the page-aligned write planner.
// Used by every module under rtl/core; depends on nothing.
package pawp_pkg;

  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned BUFFER_BYTES = 131072;
  localparam int unsigned PW           = $clog2(PAGE_BYTES);

  localparam int unsigned LEN_W  = 24;   // request length, src offset, length
  localparam int unsigned BC_W   = 18;   // buffered byte count
  localparam int unsigned WM_W   = 18;   // watermark register
  localparam int unsigned OFS_W  = 48;   // file offset
  localparam int unsigned CFG_W  = 48;   // widest config register
  localparam int unsigned OUT_W  = 104;  // result tdata, padded to bytes

  // result tdata layout
  localparam int unsigned OUT_KIND_LSB = 0;
  localparam int unsigned OUT_SRC_LSB  = 2;
  localparam int unsigned OUT_DST_LSB  = OUT_SRC_LSB + LEN_W;
  localparam int unsigned OUT_LEN_LSB  = OUT_DST_LSB + OFS_W;
  localparam int unsigned OUT_PAD_LSB  = OUT_LEN_LSB + LEN_W;

  localparam logic [WM_W-1:0] WM_MAX = WM_W'(BUFFER_BYTES);

  typedef enum logic [1:0] {
    CMD_COPY   = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_DIRECT = 2'd2,
    CMD_DONE   = 2'd3
  } cmd_kind_t;

  typedef enum logic [0:0] {
    REG_WATERMARK    = 1'b0,
    REG_START_OFFSET = 1'b1
  } cfg_reg_t;

  // order in which the back end issues the words of one plan
  typedef enum logic [2:0] {
    STEP_HEAD   = 3'd0,
    STEP_FLUSH  = 3'd1,
    STEP_DIRECT = 3'd2,
    STEP_TAIL   = 3'd3,
    STEP_DONE   = 3'd4
  } step_t;

  localparam int unsigned NSTEP = 5;

  typedef struct packed {
    logic            we;
    cfg_reg_t        idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  // one classified request, as queued between front and back
  typedef struct packed {
    logic             head_en;    // copy into buffer at current fill
    logic [BC_W-1:0]  head_len;
    logic [BC_W-1:0]  head_dst;
    logic             flush_en;
    logic [BC_W-1:0]  flush_len;
    logic             direct_en;
    logic [PW:0]      direct_src;
    logic [LEN_W-1:0] direct_len;
    logic             tail_en;
    logic [PW:0]      tail_len;
    logic [LEN_W-1:0] total;
  } plan_t;

endpackage

[rtl/core/pawp_front.sv]
// Front end: accepts a request, classifies it against the buffer state
// and produces one plan per request. Depends on pawp_pkg.
module pawp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pawp_pkg::LEN_W-1:0] in_len,
  input  logic [pawp_pkg::WM_W-1:0]  wm_eff,
  input  pawp_pkg::cfg_wr_t          cfg,
  input  logic                       q_full,
  output logic                       q_push,
  output pawp_pkg::plan_t            q_data
);
  import pawp_pkg::*;

  logic [BC_W-1:0]  bc_r, bc_nxt;
  logic [PW-1:0]    phase_r, phase_nxt;   // (file offset + buffered) mod page

  logic [LEN_W:0]   fit_sum;
  logic             fits, nonzero, head_page, slack_gt, early, full_path, direct;
  logic [PW:0]      slack;
  logic [LEN_W-1:0] c, len1, bytes;
  logic [BC_W-1:0]  bc1;
  logic [PW:0]      tail;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    nonzero   = in_len != '0;
    fit_sum   = {1'b0, in_len} + (LEN_W+1)'(bc_r);
    fits      = fit_sum <= (LEN_W+1)'(wm_eff);
    head_page = phase_r != '0;
    slack     = (PW+1)'(PAGE_BYTES) - {1'b0, phase_r};
    slack_gt  = LEN_W'(slack) > in_len;
    c         = head_page ? (slack_gt ? in_len : LEN_W'(slack)) : '0;
    early     = head_page && slack_gt;
    len1      = in_len - c;
    bc1       = bc_r + BC_W'(c);
    direct    = len1 > LEN_W'(PAGE_BYTES);
    bytes     = {len1[LEN_W-1:PW], {PW{1'b0}}};
    tail      = direct ? {1'b0, len1[PW-1:0]} : len1[PW:0];
    full_path = nonzero && !fits && !early;
  end

  always_comb begin
    q_data.head_en    = nonzero && (fits || head_page);
    q_data.head_len   = fits ? BC_W'(in_len) : BC_W'(c);
    q_data.head_dst   = bc_r;
    q_data.flush_en   = full_path && (bc1 != '0);
    q_data.flush_len  = bc1;
    q_data.direct_en  = full_path && direct;
    q_data.direct_src = c[PW:0];
    q_data.direct_len = bytes;
    q_data.tail_en    = full_path && (tail != '0);
    q_data.tail_len   = tail;
    q_data.total      = in_len;
  end

  always_comb begin
    bc_nxt    = bc_r;
    phase_nxt = phase_r;
    if (cfg.we && cfg.idx == REG_START_OFFSET) begin
      phase_nxt = cfg.data[PW-1:0] + bc_r[PW-1:0];
    end else if (q_push && nonzero) begin
      if (fits) begin
        bc_nxt    = bc_r + BC_W'(in_len);
        phase_nxt = phase_r + in_len[PW-1:0];
      end else if (early) begin
        bc_nxt    = bc1;
        phase_nxt = phase_r + in_len[PW-1:0];
      end else begin
        // page completed and flushed: only the tail remains buffered
        bc_nxt    = BC_W'(tail);
        phase_nxt = tail[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r    <= '0;
      phase_r <= '0;
    end else begin
      bc_r    <= bc_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

[rtl/core/pawp_fifo.sv]
// Short plan queue between front and back end.
// Depends on pawp_pkg for the plan type.
module pawp_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pawp_pkg::plan_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output pawp_pkg::plan_t rdata
);
  import pawp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  plan_t          q_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign valid   = cnt_r != '0;
  assign rdata   = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/core/pawp_back.sv]
// Back end: walks one plan and issues its command words through the
// output register; owns the file offset. Depends on pawp_pkg.
module pawp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  pawp_pkg::plan_t            q_data,
  output logic                       q_pop,
  input  pawp_pkg::cfg_wr_t          cfg,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pawp_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import pawp_pkg::*;

  plan_t            cur_r, cur_nxt;
  logic [NSTEP-1:0] pend_r, pend_nxt, sel_oh;
  step_t            sel;
  logic [OFS_W-1:0] fo_r, fo_nxt;

  logic             vld_r, vld_nxt;
  cmd_kind_t        kind_r, kind_nxt;
  logic [LEN_W-1:0] src_r, src_nxt, len_r, len_nxt;
  logic [OFS_W-1:0] dst_r, dst_nxt;
  logic             last_r, last_nxt;

  logic             active, ld, finishing;

  assign active = pend_r != '0;
  assign ld     = active && (!vld_r || out_tready);

  // lowest pending step goes next
  always_comb begin
    sel = STEP_DONE;
    for (int i = NSTEP - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = step_t'(i);
      end
    end
    sel_oh = '0;
    sel_oh[sel] = 1'b1;
  end

  assign finishing = ld && (sel == STEP_DONE);
  assign q_pop     = q_valid && (!active || finishing);

  always_comb begin
    cur_nxt  = cur_r;
    pend_nxt = ld ? (pend_r & ~sel_oh) : pend_r;
    if (q_pop) begin
      cur_nxt                = q_data;
      pend_nxt               = '0;
      pend_nxt[STEP_HEAD]    = q_data.head_en;
      pend_nxt[STEP_FLUSH]   = q_data.flush_en;
      pend_nxt[STEP_DIRECT]  = q_data.direct_en;
      pend_nxt[STEP_TAIL]    = q_data.tail_en;
      pend_nxt[STEP_DONE]    = 1'b1;
    end
  end

  always_comb begin
    kind_nxt = kind_r;
    src_nxt  = src_r;
    dst_nxt  = dst_r;
    len_nxt  = len_r;
    last_nxt = last_r;
    fo_nxt   = fo_r;
    vld_nxt  = vld_r && !out_tready;
    if (ld) begin
      vld_nxt  = 1'b1;
      last_nxt = 1'b0;
      src_nxt  = '0;
      dst_nxt  = '0;
      case (sel)
        STEP_HEAD: begin
          kind_nxt = CMD_COPY;
          dst_nxt  = OFS_W'(cur_r.head_dst);
          len_nxt  = LEN_W'(cur_r.head_len);
        end
        STEP_FLUSH: begin
          kind_nxt = CMD_FLUSH;
          dst_nxt  = fo_r;
          len_nxt  = LEN_W'(cur_r.flush_len);
          fo_nxt   = fo_r + OFS_W'(cur_r.flush_len);
        end
        STEP_DIRECT: begin
          kind_nxt = CMD_DIRECT;
          src_nxt  = LEN_W'(cur_r.direct_src);
          dst_nxt  = fo_r;
          len_nxt  = cur_r.direct_len;
          fo_nxt   = fo_r + OFS_W'(cur_r.direct_len);
        end
        STEP_TAIL: begin
          kind_nxt = CMD_COPY;
          src_nxt  = cur_r.total - LEN_W'(cur_r.tail_len);
          len_nxt  = LEN_W'(cur_r.tail_len);
        end
        default: begin
          kind_nxt = CMD_DONE;
          len_nxt  = cur_r.total;
          last_nxt = 1'b1;
        end
      endcase
    end
    if (cfg.we && cfg.idx == REG_START_OFFSET) begin
      fo_nxt = cfg.data[OFS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      vld_r  <= 1'b0;
      fo_r   <= '0;
    end else begin
      pend_r <= pend_nxt;
      vld_r  <= vld_nxt;
      fo_r   <= fo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    kind_r <= kind_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_W - OUT_PAD_LSB){1'b0}}, len_r, dst_r, src_r, kind_r};

endmodule

[rtl/core/page_aligned_write_planner.sv]
// Page-aligned write planner: turns each write request length into the
// copy / flush / direct-write / done commands of a write-combining buffer.
// Top level; depends on pawp_pkg, pawp_front, pawp_fifo and pawp_back.
//
// Each request on in_* yields one to five result words on out_*: an
// optional copy into the buffer, an optional flush, an optional direct
// write of whole pages, an optional tail copy and always a done word
// (tlast high) carrying the request length. The front end classifies a
// request combinationally and can take a new request every cycle while the
// plan queue has room; the result channel issues one word per cycle while
// the sink is ready, and a request has one to five result words (at most
// five for a write that crosses pages with a non-empty buffer). The output
// register decouples the result channel, so a stalled sink does not stop
// the front end until the queue fills. Config writes are taken at any
// time but only make sense while the block is idle; writing start_offset
// reloads the file offset at once. Pages are 4096 bytes, the buffer
// 131072 bytes; the watermark is clamped to the buffer size.
module page_aligned_write_planner #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [pawp_pkg::LEN_W-1:0] in_tdata,   // [23:0] write_len
  // result channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [1:0] command_kind, [25:2] src_offset, [73:26] dst_offset,
  // [97:74] length, [103:98] zero
  output logic [pawp_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast,  // last: set on done word
  // config write port: 0 watermark_bytes, 1 start_offset
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [pawp_pkg::CFG_W-1:0] cfg_data
);
  import pawp_pkg::*;

  cfg_wr_t         cfg;
  logic [WM_W-1:0] wm_r, wm_nxt;    // effective watermark, already clamped

  logic            q_full, q_push, q_pop, q_valid;
  plan_t           q_wdata, q_rdata;

  assign cfg.we   = cfg_we;
  assign cfg.idx  = cfg_reg_t'(cfg_index);
  assign cfg.data = cfg_data;

  always_comb begin
    wm_nxt = wm_r;
    if (cfg.we && cfg.idx == REG_WATERMARK) begin
      wm_nxt = (cfg.data[WM_W-1:0] > WM_MAX) ? WM_MAX : cfg.data[WM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm_r <= WM_MAX;
    end else begin
      wm_r <= wm_nxt;
    end
  end

  // classify; tracks buffered count and page phase
  pawp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_len   (in_tdata),
    .wm_eff   (wm_r),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  pawp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // issue commands; tracks file offset
  pawp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // ---- checks ----
  cmd_kind_t        a_kind;
  logic [OFS_W-1:0] a_dst;
  logic [LEN_W-1:0] a_len;

  assign a_kind = cmd_kind_t'(out_tdata[OUT_KIND_LSB +: 2]);
  assign a_dst  = out_tdata[OUT_DST_LSB +: OFS_W];
  assign a_len  = out_tdata[OUT_LEN_LSB +: LEN_W];

  // tlast marks the done word and nothing else
  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (a_kind == CMD_DONE)))
    else $error("tlast does not match done word");

  // a buffer copy stays inside buffer plus one page of slack
  a_copy_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && a_kind == CMD_COPY) |->
      ((OFS_W+1)'(a_dst) + (OFS_W+1)'(a_len) <=
       (OFS_W+1)'(BUFFER_BYTES + PAGE_BYTES)))
    else $error("copy runs past buffer");

  // direct writes are whole pages, at least one
  a_direct_pages: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && a_kind == CMD_DIRECT) |->
      (a_len[PW-1:0] == '0 && a_len >= LEN_W'(PAGE_BYTES)))
    else $error("direct write not page multiple");

endmodule
